// ===== sv/nppl_pkg.sv =====
`default_nettype none
package nppl_pkg;

    // Palette size and label codes
    localparam int NUM_LABELS = 33;
    localparam int LABEL_W = 6;
    localparam logic [LABEL_W-1:0] FIRST_LABEL = 6'd0;
    localparam logic [LABEL_W-1:0] LAST_LABEL = 6'd32;

    // Distance of three squared 8-bit differences
    localparam int DIST_W = 18;

    // Reported count field
    localparam int COUNT_FIELD_W = 24;
    localparam logic [COUNT_FIELD_W-1:0] COUNT_FIELD_MAX = 24'hFF_FFFF;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               first_pixel;
        logic               last_pixel;
    } q_entry_t;

    // Palette levels {red, green, blue}, three bits each
    function automatic logic [8:0] pal_level(input logic [LABEL_W-1:0] idx);
        logic [8:0] lv;
        case (idx)
            6'd0:    lv = {3'd1, 3'd0, 3'd0};
            6'd1:    lv = {3'd0, 3'd1, 3'd0};
            6'd2:    lv = {3'd4, 3'd0, 3'd0};
            6'd3:    lv = {3'd2, 3'd0, 3'd1};
            6'd4:    lv = {3'd2, 3'd4, 3'd0};
            6'd5:    lv = {3'd3, 3'd4, 3'd3};
            6'd6:    lv = {3'd4, 3'd4, 3'd3};
            6'd7:    lv = {3'd2, 3'd4, 3'd2};
            6'd8:    lv = {3'd3, 3'd3, 3'd3};
            6'd9:    lv = {3'd1, 3'd2, 3'd0};
            6'd10:   lv = {3'd0, 3'd3, 3'd1};
            6'd11:   lv = {3'd4, 3'd4, 3'd0};
            6'd12:   lv = {3'd4, 3'd3, 3'd0};
            6'd13:   lv = {3'd0, 3'd4, 3'd4};
            6'd14:   lv = {3'd0, 3'd3, 3'd4};
            6'd15:   lv = {3'd2, 3'd1, 3'd0};
            6'd16:   lv = {3'd0, 3'd1, 3'd2};
            6'd17:   lv = {3'd4, 3'd1, 3'd4};
            6'd18:   lv = {3'd1, 3'd4, 3'd4};
            6'd19:   lv = {3'd4, 3'd1, 3'd0};
            6'd20:   lv = {3'd0, 3'd1, 3'd4};
            6'd21:   lv = {3'd2, 3'd1, 3'd4};
            6'd22:   lv = {3'd2, 3'd1, 3'd1};
            6'd23:   lv = {3'd1, 3'd2, 3'd4};
            6'd24:   lv = {3'd4, 3'd1, 3'd1};
            6'd25:   lv = {3'd1, 3'd0, 3'd1};
            6'd26:   lv = {3'd1, 3'd0, 3'd2};
            6'd27:   lv = {3'd4, 3'd2, 3'd2};
            6'd28:   lv = {3'd1, 3'd4, 3'd1};
            6'd29:   lv = {3'd3, 3'd2, 3'd1};
            6'd30:   lv = {3'd1, 3'd1, 3'd0};
            6'd31:   lv = {3'd0, 3'd0, 3'd0};
            6'd32:   lv = {3'd4, 3'd4, 3'd4};
            default: lv = {3'd0, 3'd0, 3'd0};
        endcase
        return lv;
    endfunction

    // Level to component: max(0, level*64-1)
    function automatic logic [7:0] level_value(input logic [2:0] lv);
        logic [7:0] v;
        case (lv)
            3'd1:    v = 8'd63;
            3'd2:    v = 8'd127;
            3'd3:    v = 8'd191;
            3'd4:    v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // Palette colour {red, green, blue}
    function automatic logic [23:0] pal_rgb(input logic [LABEL_W-1:0] idx);
        logic [8:0] lv;
        lv = pal_level(idx);
        return {level_value(lv[8:6]), level_value(lv[5:3]), level_value(lv[2:0])};
    endfunction

    // Squared absolute difference of two components
    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

endpackage
`default_nettype wire

// ===== sv/nppl_front.sv =====
`default_nettype none
module nppl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        blue,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        red,
    input  wire logic              first_pixel,
    input  wire logic              last_pixel,
    output logic                   q_push,
    output nppl_pkg::q_entry_t     q_data,
    input  wire logic              q_full
);
    import nppl_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SCAN = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic [7:0]          blue_reg, green_reg, red_reg;
    logic                first_reg, last_reg;
    logic [LABEL_W-1:0]  idx_reg, idx_next;
    logic [LABEL_W-1:0]  best_reg, best_next;
    logic [DIST_W-1:0]   best_d_reg, best_d_next;
    logic [23:0]         cand_rgb;
    logic [DIST_W-1:0]   cand_d;
    logic                take;

    // Distance to the palette entry under scan
    always_comb
    begin
        cand_rgb = pal_rgb(idx_reg);
        cand_d = DIST_W'(sq_diff(red_reg, cand_rgb[23:16]))
               + DIST_W'(sq_diff(green_reg, cand_rgb[15:8]))
               + DIST_W'(sq_diff(blue_reg, cand_rgb[7:0]));
    end

    assign full = (state_reg != F_IDLE);
    assign take = push && !full;
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = '{label: best_reg, first_pixel: first_reg, last_pixel: last_reg};

    // Scan sequencer: one palette entry per cycle, lowest index kept on a tie
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        best_next = best_reg;
        best_d_next = best_d_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    idx_next = FIRST_LABEL;
                    best_next = FIRST_LABEL;
                    best_d_next = '1;
                    state_next = F_SCAN;
                end
            end
            F_SCAN:
            begin
                if (cand_d < best_d_reg)
                begin
                    best_d_next = cand_d;
                    best_next = idx_reg;
                end
                if (idx_reg == LAST_LABEL)
                    state_next = F_PUSH;
                else
                    idx_next = idx_reg + 1'b1;
            end
            F_PUSH:
            begin
                if (q_push)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pixel and scan registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blue_reg <= blue;
            green_reg <= green;
            red_reg <= red;
            first_reg <= first_pixel;
            last_reg <= last_pixel;
        end
        idx_reg <= idx_next;
        best_reg <= best_next;
        best_d_reg <= best_d_next;
    end

endmodule
`default_nettype wire

// ===== sv/nppl_queue.sv =====
`default_nettype none
module nppl_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire nppl_pkg::q_entry_t wr_data,
    output logic                   q_full,
    input  wire logic              rd_en,
    output nppl_pkg::q_entry_t     rd_data,
    output logic                   q_empty
);
    import nppl_pkg::*;

    q_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;
    logic               do_wr, do_rd;

    assign q_full = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (fill_reg == '0);
    assign do_wr = wr_en && !q_full;
    assign do_rd = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                fill_reg <= fill_reg + 1'b1;
            else if (do_rd && !do_wr)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== sv/nppl_back.sv =====
`default_nettype none
module nppl_back #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire nppl_pkg::q_entry_t q_data,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   kind,
    output logic [5:0]             label,
    output logic [7:0]             out_blue,
    output logic [7:0]             out_green,
    output logic [7:0]             out_red,
    output logic [23:0]            count,
    output logic                   last
);
    import nppl_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;

    typedef enum logic [5:0] {
        B_IDLE     = 6'b000001,
        B_READ     = 6'b000010,
        B_UPDATE   = 6'b000100,
        B_EMIT     = 6'b001000,
        B_DUMP_RD  = 6'b010000,
        B_DUMP_OUT = 6'b100000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [LABEL_W-1:0]       item_label_reg;
    logic                     item_last_reg;
    logic [LABEL_W-1:0]       idx_reg, idx_next;
    logic [NUM_LABELS-1:0]    valid_reg, valid_next;
    logic [COUNT_WIDTH-1:0]   cnt_mem [NUM_LABELS];
    logic [COUNT_WIDTH-1:0]   rd_data_reg;
    logic                     rd_valid_reg;
    logic [LABEL_W-1:0]       mem_addr;
    logic                     mem_re, mem_we;
    logic [COUNT_WIDTH-1:0]   cur_cnt, inc_cnt;
    logic [EXT_W-1:0]         cur_ext;
    logic [COUNT_FIELD_W-1:0] cur_sat;
    logic                     out_valid_reg;
    logic                     slot_free;
    logic                     load_out;
    logic                     load_kind;
    logic [LABEL_W-1:0]       load_label;
    logic [COUNT_FIELD_W-1:0] load_count;
    logic                     load_last;
    logic [23:0]              load_rgb;

    assign slot_free = !out_valid_reg || pop;
    assign empty = !out_valid_reg;
    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    // Count memory port
    assign mem_addr = (state_reg == B_DUMP_RD) ? idx_reg : item_label_reg;
    assign mem_re = (state_reg == B_READ) || (state_reg == B_DUMP_RD);
    assign mem_we = (state_reg == B_UPDATE);

    // Saturating increment and clamp to the reported field
    always_comb
    begin
        cur_cnt = rd_valid_reg ? rd_data_reg : '0;
        inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
        cur_ext = EXT_W'(cur_cnt);
        cur_sat = (cur_ext > EXT_W'(COUNT_FIELD_MAX)) ? COUNT_FIELD_MAX
                                                      : cur_ext[COUNT_FIELD_W-1:0];
    end

    // Sequencer: count the label, emit its result, then dump on a last pixel
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        valid_next = valid_reg;
        load_out = 1'b0;
        load_kind = KIND_PIXEL;
        load_label = item_label_reg;
        load_count = '0;
        load_last = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_data.first_pixel)
                        valid_next = '0;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_UPDATE;
            end
            B_UPDATE:
            begin
                valid_next[item_label_reg] = 1'b1;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    load_kind = KIND_PIXEL;
                    load_label = item_label_reg;
                    load_count = '0;
                    load_last = !item_last_reg;
                    if (item_last_reg)
                    begin
                        idx_next = FIRST_LABEL;
                        state_next = B_DUMP_RD;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_DUMP_RD:
            begin
                state_next = B_DUMP_OUT;
            end
            B_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    load_kind = KIND_COUNT;
                    load_label = idx_reg;
                    load_count = cur_sat;
                    load_last = (idx_reg == LAST_LABEL);
                    if (idx_reg == LAST_LABEL)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = B_DUMP_RD;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
        load_rgb = pal_rgb(load_label);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Count memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cnt_mem[mem_addr] <= inc_cnt;
        if (mem_re)
        begin
            rd_data_reg <= cnt_mem[mem_addr];
            rd_valid_reg <= valid_reg[mem_addr];
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_label_reg <= q_data.label;
            item_last_reg <= q_data.last_pixel;
        end
        idx_reg <= idx_next;
        if (load_out)
        begin
            kind <= load_kind;
            label <= load_label;
            out_red <= load_rgb[23:16];
            out_green <= load_rgb[15:8];
            out_blue <= load_rgb[7:0];
            count <= load_count;
            last <= load_last;
        end
    end

endmodule
`default_nettype wire

// ===== sv/nearest_palette_pixel_labeler_top.sv =====
// Nearest-palette pixel labeler with label histogram.
// Input queue side: present blue, green, red, first_pixel and last_pixel with
// push; a transfer happens on a clock edge with push high and full low.
// Result queue side: the oldest result sits on kind, label, out_blue,
// out_green, out_red, count and last while empty is low; pop takes it.
// Each pixel gives one kind 0 result (its label and palette colour); a pixel
// with last_pixel also gives 33 kind 1 results carrying the label counts,
// the final one marked by last. first_pixel clears the counts first.
// The front takes a new pixel only once the previous label is queued; its scan
// runs one distance unit over the 33 palette entries, one entry per cycle.
// The histogram read-out passes DUMP_RD and DUMP_OUT per count (one memory
// read port); a four-entry queue lets the front keep labelling meanwhile.
// A stalled receiver holds the result register; the back stops, the queue
// fills and full then rises. Reset empties both queues and marks every
// count as zero at once, with no clearing pass.
`default_nettype none
module nearest_palette_pixel_labeler_top #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic        first_pixel,
    input  wire logic        last_pixel,
    output logic             empty,
    input  wire logic        pop,
    output logic             kind,
    output logic [5:0]       label,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_green,
    output logic [7:0]       out_red,
    output logic [23:0]      count,
    output logic             last
);
    import nppl_pkg::*;

    logic     f_push, f_full;
    q_entry_t f_data;
    logic     b_pop, b_empty;
    q_entry_t b_data;

    // Classify pixels
    nppl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .first_pixel (first_pixel),
        .last_pixel  (last_pixel),
        .q_push      (f_push),
        .q_data      (f_data),
        .q_full      (f_full)
    );

    // Decouple front and back
    nppl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_data),
        .q_full  (f_full),
        .rd_en   (b_pop),
        .rd_data (b_data),
        .q_empty (b_empty)
    );

    // Count labels and emit results
    nppl_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (b_empty),
        .q_data    (b_data),
        .q_pop     (b_pop),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .label     (label),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .count     (count),
        .last      (last)
    );

endmodule
`default_nettype wire

// ===== verif/palette_label_checker.sv =====
`timescale 1ns / 100ps
module palette_label_checker #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic        first_pixel,
    input  wire logic        last_pixel,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        kind,
    input  wire logic [5:0]  label,
    input  wire logic [7:0]  out_blue,
    input  wire logic [7:0]  out_green,
    input  wire logic [7:0]  out_red,
    input  wire logic [23:0] count,
    input  wire logic        last,
    output int               fail_count,
    output int               outstanding,
    output int               checked_count
);
    import nppl_pkg::*;

    typedef struct packed {
        logic                     kind;
        logic [LABEL_W-1:0]       label;
        logic [7:0]               blue;
        logic [7:0]               green;
        logic [7:0]               red;
        logic [COUNT_FIELD_W-1:0] count;
        logic                     last;
    } labelled_result_t;

    // Palette levels as octal digits {red, green, blue}
    localparam logic [8:0] PALETTE_LEVELS [NUM_LABELS] = '{
        9'o100, 9'o010, 9'o400, 9'o201, 9'o240, 9'o343, 9'o443, 9'o242,
        9'o333, 9'o120, 9'o031, 9'o440, 9'o430, 9'o044, 9'o034, 9'o210,
        9'o012, 9'o414, 9'o144, 9'o410, 9'o014, 9'o214, 9'o211, 9'o124,
        9'o411, 9'o101, 9'o102, 9'o422, 9'o141, 9'o321, 9'o110, 9'o000,
        9'o444
    };

    localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    labelled_result_t       awaited_results[$];
    logic [COUNT_WIDTH-1:0] label_tally [NUM_LABELS];
    int                     mismatches = 0;
    int                     results_seen = 0;
    int                     results_waiting = 0;

    assign fail_count    = mismatches;
    assign outstanding   = results_waiting;
    assign checked_count = results_seen;

    // Level 0 is black, otherwise level*64-1
    function automatic logic [7:0] component(input logic [2:0] lv);
        return (lv == 3'd0) ? 8'd0 : 8'(int'(lv) * 64 - 1);
    endfunction

    // Scan the palette; strict less-than keeps the lowest index on a tie
    function automatic logic [LABEL_W-1:0] nearest_label(input logic [7:0] b,
                                                         input logic [7:0] g,
                                                         input logic [7:0] r);
        int                 i;
        int                 dr;
        int                 dg;
        int                 db;
        int                 sq_dist;
        int                 best_dist;
        logic [LABEL_W-1:0] best;
        best_dist = 32'h7FFF_FFFF;
        best = FIRST_LABEL;
        for (i = 0; i < NUM_LABELS; i++)
        begin
            dr = int'(r) - int'(component(PALETTE_LEVELS[i][8:6]));
            dg = int'(g) - int'(component(PALETTE_LEVELS[i][5:3]));
            db = int'(b) - int'(component(PALETTE_LEVELS[i][2:0]));
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist)
            begin
                best_dist = sq_dist;
                best = LABEL_W'(i);
            end
        end
        return best;
    endfunction

    // Build one result with the palette colour of its label
    function automatic labelled_result_t labelled_result(input logic             k,
                                                         input logic [LABEL_W-1:0] idx,
                                                         input longint unsigned tally,
                                                         input logic             fin);
        labelled_result_t res;
        res.kind  = k;
        res.label = idx;
        res.red   = component(PALETTE_LEVELS[idx][8:6]);
        res.green = component(PALETTE_LEVELS[idx][5:3]);
        res.blue  = component(PALETTE_LEVELS[idx][2:0]);
        res.count = (tally > longint'(COUNT_FIELD_MAX)) ? COUNT_FIELD_MAX
                                                        : COUNT_FIELD_W'(tally);
        res.last  = fin;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: result %0d, %s is %0h, expected %0h",
                 $time, results_seen, field, got, want);
        mismatches++;
    endtask

    // Clear, count this pixel, then queue its label and any histogram dump
    task automatic label_and_tally(input logic [7:0] b, input logic [7:0] g,
                                   input logic [7:0] r, input logic f,
                                   input logic l);
        int                 i;
        logic [LABEL_W-1:0] lab;
        lab = nearest_label(b, g, r);
        if (f)
        begin
            for (i = 0; i < NUM_LABELS; i++)
                label_tally[i] = '0;
        end
        if (longint'(label_tally[lab]) < TALLY_MAX)
            label_tally[lab] = label_tally[lab] + 1'b1;
        awaited_results.push_back(labelled_result(KIND_PIXEL, lab, 64'd0, !l));
        if (l)
        begin
            for (i = 0; i < NUM_LABELS; i++)
                awaited_results.push_back(labelled_result(KIND_COUNT, LABEL_W'(i),
                                                          64'(label_tally[i]),
                                                          i == int'(LAST_LABEL)));
        end
    endtask

    // Compare each result transfer against the oldest prediction
    task automatic compare_result;
        labelled_result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result, label", 32'(label), 32'd0);
        end
        else
        begin
            want = awaited_results.pop_front();
            if (kind !== want.kind)
                report_mismatch("kind", 32'(kind), 32'(want.kind));
            if (label !== want.label)
                report_mismatch("label", 32'(label), 32'(want.label));
            if (out_blue !== want.blue)
                report_mismatch("out_blue", 32'(out_blue), 32'(want.blue));
            if (out_green !== want.green)
                report_mismatch("out_green", 32'(out_green), 32'(want.green));
            if (out_red !== want.red)
                report_mismatch("out_red", 32'(out_red), 32'(want.red));
            if (count !== want.count)
                report_mismatch("count", 32'(count), 32'(want.count));
            if (last !== want.last)
                report_mismatch("last", 32'(last), 32'(want.last));
        end
        results_seen++;
    endtask

    // Watch both transfers on every rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LABELS; i++)
                label_tally[i] = '0;
            awaited_results.delete();
            results_waiting = 0;
        end
        else
        begin
            if (pop && !empty)
                compare_result();
            if (push && !full)
                label_and_tally(blue, green, red, first_pixel, last_pixel);
            results_waiting = awaited_results.size();
        end
    end

endmodule

// ===== verif/tb_nearest_palette_pixel_labeler_top.sv =====
`timescale 1ns / 100ps
module tb_nearest_palette_pixel_labeler_top;
    import nppl_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  blue = '0;
    logic [7:0]  green = '0;
    logic [7:0]  red = '0;
    logic        first_pixel = 1'b0;
    logic        last_pixel = 1'b0;
    logic        pop = 1'b0;
    wire logic        full;
    wire logic        empty;
    wire logic        kind;
    wire logic [5:0]  label;
    wire logic [7:0]  out_blue;
    wire logic [7:0]  out_green;
    wire logic [7:0]  out_red;
    wire logic [23:0] count;
    wire logic        last;

    int fail_count;
    int outstanding;
    int checked_count;

    int pixels_sent = 0;
    int frames_sent = 0;
    int dumps_requested = 0;
    bit calm_tail = 1'b0;
    bit rx_stalls_on = 1'b1;
    int rx_stall_left = 0;

    nearest_palette_pixel_labeler_top #(
        .COUNT_WIDTH (24)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .first_pixel (first_pixel),
        .last_pixel  (last_pixel),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .label       (label),
        .out_blue    (out_blue),
        .out_green   (out_green),
        .out_red     (out_red),
        .count       (count),
        .last        (last)
    );

    palette_label_checker #(
        .COUNT_WIDTH (24)
    ) label_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .first_pixel   (first_pixel),
        .last_pixel    (last_pixel),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .label         (label),
        .out_blue      (out_blue),
        .out_green     (out_green),
        .out_red       (out_red),
        .count         (count),
        .last          (last),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: stall in bursts, toggle between stalling and free-running stretches
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            pop <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            if (!calm_tail && $urandom_range(0, 299) == 0)
                rx_stalls_on = !rx_stalls_on;
            if (!calm_tail && rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                rx_stall_left = $urandom_range(1, 13) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Hold the pixel until the transfer happens
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic f, input logic l);
        @(negedge clk);
        push        <= 1'b1;
        blue        <= b;
        green       <= g;
        red         <= r;
        first_pixel <= f;
        last_pixel  <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pixels_sent++;
        if (l)
            dumps_requested++;
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // Drop push and wait for every predicted result to drain
    task automatic drain_results;
        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Mix of random values, near-palette values, midpoints and extremes
    function automatic logic [7:0] pick_component();
        int near;
        case ($urandom_range(0, 5))
            0, 1:
                return 8'($urandom_range(0, 255));
            2, 3:
            begin
                near = int'($urandom_range(0, 4)) * 64 - 1 + int'($urandom_range(0, 8)) - 4;
                if (near < 0)
                    near = 0;
                if (near > 255)
                    near = 255;
                return 8'(near);
            end
            4:
                return 8'(32 * (2 * int'($urandom_range(0, 3)) + 1) - 1
                          + int'($urandom_range(0, 1)));
            default:
                return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        endcase
    endfunction

    initial
    begin
        int  frame_len;
        int  k;
        bit  noisy;
        bit  gaps_on;
        logic f;
        logic l;

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: counts from reset, pure primaries, tie points, both flags
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b0);
        send_pixel(8'd95,  8'd95,  8'd95,  1'b0, 1'b0);
        send_pixel(8'd32,  8'd31,  8'd32,  1'b0, 1'b0);
        send_pixel(8'd159, 8'd223, 8'd159, 1'b0, 1'b0);
        send_pixel(8'd128, 8'd127, 8'd128, 1'b0, 1'b0);
        send_pixel(8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0);
        send_pixel(8'h55,  8'hAA,  8'h55,  1'b0, 1'b1);
        send_pixel(8'd63,  8'd191, 8'd127, 1'b1, 1'b1);
        send_pixel(8'd191, 8'd191, 8'd191, 1'b0, 1'b1);
        send_pixel(8'd1,   8'd254, 8'd128, 1'b1, 1'b0);
        send_pixel(8'd254, 8'd1,   8'd127, 1'b0, 1'b1);
        drain_results();

        // Random frames, with the odd malformed one
        while (pixels_sent < 120)
        begin
            if (pixels_sent >= 100)
                calm_tail = 1'b1;
            frame_len = $urandom_range(1, 12);
            noisy = ($urandom_range(0, 5) == 0);
            gaps_on = !calm_tail && ($urandom_range(0, 3) != 0);
            for (k = 0; k < frame_len; k++)
            begin
                if (gaps_on && $urandom_range(0, 4) == 0)
                    hold_off($urandom_range(1, 13));
                if (noisy)
                begin
                    f = 1'($urandom_range(0, 1));
                    l = ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    f = (k == 0);
                    l = (k == frame_len - 1);
                end
                send_pixel(pick_component(), pick_component(), pick_component(), f, l);
            end
            frames_sent++;
            if (frames_sent == 4)
                drain_results();
        end

        // Let the last results out, then allow for any stragglers
        drain_results();
        repeat (120)
            @(negedge clk);

        $display("covered %0d pixels: a directed set and %0d random frames, %0d histogram dumps",
                 pixels_sent, frames_sent, dumps_requested);
        $display("compared %0d results against predicted labels, colours and counts",
                 checked_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
